/* rtl/pts_pkg.sv */
`timescale 1ns / 1ps

package pts_pkg;

    // Fixed field widths of the item and result ports
    localparam int THREAD_W  = 3;
    localparam int SEMA_W    = 3;
    localparam int OP_W      = 3;
    localparam int TICKS_W   = 16;
    localparam int COUNT_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int STEP_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;
    localparam int MASK_W    = 8;

    // Priority value that is never scheduled
    localparam logic [PRIO_W-1:0] NO_PRIORITY = 8'd255;

    // Saturation limits of a semaphore count
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SLEEP  = 3'd1,
        OP_WAIT   = 3'd2,
        OP_SIGNAL = 3'd3,
        OP_INIT   = 3'd4
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIORITIES = 1'b0,
        REG_VALID_MASK = 1'b1
    } cfg_reg_t;

    // Outcome of a round-robin search over the thread slots
    typedef struct packed {
        logic                found;
        logic [THREAD_W-1:0] thread;
    } pick_t;

endpackage

/* rtl/priority_thread_scheduler_semaphores.sv */
`timescale 1ns / 1ps

// Priority thread scheduler with counting semaphores. One kernel event
// (tick, sleep, wait, signal, semaphore init) is taken per transfer and
// gives exactly one result. The block sustains one event per clock
// while out_stall is low: an event waits in the input register, the
// whole update (sleep countdown, semaphore count, waiter wake-up and
// the round-robin priority scan over all threads) is done from there,
// and the result register loads as the event leaves. The cycle time is
// set by the round-robin priority scan, a chain of NUM_THREADS compares.
// The user must write thread priorities and the valid mask through the
// cfg port only while no event is in flight; the block does not enforce it.
module priority_thread_scheduler_semaphores #(
    parameter int NUM_THREADS    = 8,
    parameter int NUM_SEMAPHORES = 8,
    parameter int SLEEP_BITS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Event channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pts_pkg::OP_W-1:0]             opcode,
    input  logic [pts_pkg::SEMA_W-1:0]           sema_index,
    input  logic [pts_pkg::TICKS_W-1:0]          sleep_ticks,
    input  logic signed [pts_pkg::COUNT_W-1:0]   init_count,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pts_pkg::THREAD_W-1:0]         running_thread,
    output logic                                 switched,
    output logic                                 caller_blocked,
    output logic                                 idle,
    output logic [pts_pkg::STEP_W-1:0]           tick_count,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pts_pkg::CFG_W-1:0]            cfg_data
);

    localparam int TIDX_W = $clog2(NUM_THREADS);
    localparam int SIDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

    // Configuration
    logic [pts_pkg::CFG_W-1:0]  prio_cfg_reg;
    logic [pts_pkg::MASK_W-1:0] valid_cfg_reg;

    // Input register
    logic                                in_valid_reg;
    logic [pts_pkg::OP_W-1:0]            in_op_reg;
    logic [pts_pkg::SEMA_W-1:0]          in_sema_reg;
    logic [pts_pkg::TICKS_W-1:0]         in_ticks_reg;
    logic signed [pts_pkg::COUNT_W-1:0]  in_init_reg;

    // Scheduler state
    logic [SLEEP_BITS-1:0]              sleep_reg      [NUM_THREADS];
    logic [NUM_THREADS-1:0]             blocked_reg;
    logic [SIDX_W-1:0]                  blocked_on_reg [NUM_THREADS];
    logic signed [pts_pkg::COUNT_W-1:0] sema_reg       [NUM_SEMAPHORES];
    logic [TIDX_W-1:0]                  cur_reg;
    logic [pts_pkg::STEP_W-1:0]         step_reg;

    // Result register
    logic                               out_valid_reg;
    logic [pts_pkg::THREAD_W-1:0]       running_reg;
    logic                               switched_reg;
    logic                               blocked_out_reg;
    logic                               idle_reg;
    logic [pts_pkg::STEP_W-1:0]         tick_reg;

    // Update logic
    logic                               fire;
    logic                               in_take;
    logic                               sema_ok;
    logic [SIDX_W-1:0]                  s_idx;
    logic signed [pts_pkg::COUNT_W-1:0] cnt_cur;
    logic signed [pts_pkg::COUNT_W-1:0] cnt_dec;
    logic signed [pts_pkg::COUNT_W-1:0] cnt_inc;
    logic [SLEEP_BITS-1:0]              ticks_sat;
    logic [NUM_THREADS-1:0]             waiting;
    logic [NUM_THREADS-1:0]             valid_mask;
    logic [pts_pkg::PRIO_W-1:0]         prio      [NUM_THREADS];
    logic [SLEEP_BITS-1:0]              sleep_pre [NUM_THREADS];
    logic [SLEEP_BITS-1:0]              sleep_dec [NUM_THREADS];
    logic [NUM_THREADS-1:0]             blocked_pre;
    logic [SIDX_W-1:0]                  blocked_on_next [NUM_THREADS];
    logic signed [pts_pkg::COUNT_W-1:0] sema_next [NUM_SEMAPHORES];
    logic                               ran;
    logic                               blk;
    logic                               idle_next;
    logic [TIDX_W-1:0]                  cur_next;
    logic [pts_pkg::STEP_W-1:0]         step_next;
    pts_pkg::pick_t                     step_pick;
    pts_pkg::pick_t                     wake_pick;

    // Handshake: process when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // Semaphore addressing and saturating count updates
    assign sema_ok = (32'(in_sema_reg) < NUM_SEMAPHORES);
    assign s_idx   = in_sema_reg[SIDX_W-1:0];
    assign cnt_cur = sema_reg[s_idx];
    assign cnt_dec = (cnt_cur != pts_pkg::COUNT_MIN) ? cnt_cur - 16'sd1 : cnt_cur;
    assign cnt_inc = (cnt_cur != pts_pkg::COUNT_MAX) ? cnt_cur + 16'sd1 : cnt_cur;

    // Clamp the sleep length to the sleep counter range
    if (SLEEP_BITS >= pts_pkg::TICKS_W) begin : g_ticks_wide
        assign ticks_sat = SLEEP_BITS'(in_ticks_reg);
    end else begin : g_ticks_narrow
        assign ticks_sat = (|in_ticks_reg[pts_pkg::TICKS_W-1:SLEEP_BITS]) ?
                           '1 : in_ticks_reg[SLEEP_BITS-1:0];
    end

    // Per-thread views of configuration and waiters
    assign valid_mask = valid_cfg_reg[NUM_THREADS-1:0];
    for (genvar g = 0; g < NUM_THREADS; g++) begin : g_thread
        assign prio[g]    = prio_cfg_reg[pts_pkg::PRIO_W*g +: pts_pkg::PRIO_W];
        assign waiting[g] = blocked_reg[g] && (blocked_on_reg[g] == s_idx);
    end

    pts_wake #(
        .NUM_THREADS (NUM_THREADS)
    ) u_wake (
        .waiting (waiting),
        .cur     (cur_reg),
        .pick    (wake_pick)
    );

    // Decode the event into the state seen by the scheduling step
    always_comb
    begin
        sleep_pre       = sleep_reg;
        blocked_pre     = blocked_reg;
        blocked_on_next = blocked_on_reg;
        sema_next       = sema_reg;
        ran             = 1'b0;
        blk             = 1'b0;
        unique case (pts_pkg::opcode_t'(in_op_reg))
            pts_pkg::OP_TICK:
            begin
                ran = 1'b1;
            end
            pts_pkg::OP_SLEEP:
            begin
                sleep_pre[cur_reg] = ticks_sat;
                ran                = 1'b1;
            end
            pts_pkg::OP_WAIT:
            begin
                if (sema_ok)
                begin
                    sema_next[s_idx] = cnt_dec;
                    if (cnt_dec[pts_pkg::COUNT_W-1])
                    begin
                        blocked_pre[cur_reg]     = 1'b1;
                        blocked_on_next[cur_reg] = s_idx;
                        blk                      = 1'b1;
                        ran                      = 1'b1;
                    end
                end
            end
            pts_pkg::OP_SIGNAL:
            begin
                if (sema_ok)
                begin
                    sema_next[s_idx] = cnt_inc;
                    if ((cnt_inc[pts_pkg::COUNT_W-1] || (cnt_inc == '0)) && wake_pick.found)
                    begin
                        blocked_pre[wake_pick.thread[TIDX_W-1:0]]     = 1'b0;
                        blocked_on_next[wake_pick.thread[TIDX_W-1:0]] = '0;
                    end
                end
            end
            pts_pkg::OP_INIT:
            begin
                if (sema_ok)
                begin
                    sema_next[s_idx] = in_init_reg;
                end
            end
            default:
            begin
                ran = 1'b0;
            end
        endcase
    end

    pts_step #(
        .NUM_THREADS (NUM_THREADS),
        .SLEEP_BITS  (SLEEP_BITS)
    ) u_step (
        .sleep_pre (sleep_pre),
        .blocked   (blocked_pre),
        .valid     (valid_mask),
        .prio      (prio),
        .cur       (cur_reg),
        .sleep_dec (sleep_dec),
        .pick      (step_pick)
    );

    // Commit the step only when the event calls for one
    assign idle_next = ran && !step_pick.found;
    assign cur_next  = (ran && step_pick.found) ? step_pick.thread[TIDX_W-1:0] : cur_reg;
    assign step_next = step_reg + pts_pkg::STEP_W'(ran);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_cfg_reg  <= '1;
            valid_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pts_pkg::cfg_reg_t'(cfg_index))
                pts_pkg::REG_PRIORITIES: prio_cfg_reg  <= cfg_data;
                pts_pkg::REG_VALID_MASK: valid_cfg_reg <= cfg_data[pts_pkg::MASK_W-1:0];
                default:                 prio_cfg_reg  <= prio_cfg_reg;
            endcase
        end
    end

    // Hold the accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= opcode;
            in_sema_reg  <= sema_index;
            in_ticks_reg <= sleep_ticks;
            in_init_reg  <= init_count;
        end
    end

    // Advance scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                sleep_reg[i]      <= '0;
                blocked_on_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SEMAPHORES; i++)
            begin
                sema_reg[i] <= '0;
            end
            blocked_reg <= '0;
            cur_reg     <= '0;
            step_reg    <= '0;
        end
        else if (fire)
        begin
            sleep_reg      <= ran ? sleep_dec : sleep_pre;
            blocked_on_reg <= blocked_on_next;
            sema_reg       <= sema_next;
            blocked_reg    <= blocked_pre;
            cur_reg        <= cur_next;
            step_reg       <= step_next;
        end
    end

    // Load the result register; drop valid once the result transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            running_reg     <= pts_pkg::THREAD_W'(cur_next);
            switched_reg    <= ran;
            blocked_out_reg <= blk;
            idle_reg        <= idle_next;
            tick_reg        <= step_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign running_thread = running_reg;
    assign switched       = switched_reg;
    assign caller_blocked = blocked_out_reg;
    assign idle           = idle_reg;
    assign tick_count     = tick_reg;

    // The step counter moves by one exactly when a step runs
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> ((step_reg - $past(step_reg)) == pts_pkg::STEP_W'($past(ran))))
        else $error("step counter out of line with scheduling steps");

    // A thread picked by a step is never left blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ran && step_pick.found) |=> !blocked_reg[cur_reg])
        else $error("blocked thread was scheduled");

    // A waiting event is not overwritten before it is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_op_reg)))
        else $error("pending event lost");

endmodule

/* rtl/pts_step.sv */
`timescale 1ns / 1ps

module pts_step #(
    parameter int NUM_THREADS = 8,
    parameter int SLEEP_BITS  = 16,
    localparam int TIDX_W     = $clog2(NUM_THREADS)
) (
    input  logic [SLEEP_BITS-1:0]        sleep_pre [NUM_THREADS],
    input  logic [NUM_THREADS-1:0]       blocked,
    input  logic [NUM_THREADS-1:0]       valid,
    input  logic [pts_pkg::PRIO_W-1:0]   prio [NUM_THREADS],
    input  logic [TIDX_W-1:0]            cur,
    output logic [SLEEP_BITS-1:0]        sleep_dec [NUM_THREADS],
    output pts_pkg::pick_t               pick
);

    logic [NUM_THREADS-1:0] ready;

    // Count down every sleeping thread and mark the ones that may run
    for (genvar g = 0; g < NUM_THREADS; g++) begin : g_thread
        assign sleep_dec[g] = (sleep_pre[g] != '0) ? sleep_pre[g] - 1'b1 : sleep_pre[g];
        assign ready[g]     = valid[g] && !blocked[g] && (sleep_dec[g] == '0);
    end

    // Scan from the thread after the running one, ending at the running one;
    // the first thread scanned wins a tie
    always_comb
    begin
        logic [TIDX_W:0]            sum;
        logic [TIDX_W-1:0]          t;
        logic [pts_pkg::PRIO_W-1:0] best;
        best        = pts_pkg::NO_PRIORITY;
        pick.found  = 1'b0;
        pick.thread = pts_pkg::THREAD_W'(cur);
        for (int i = 1; i <= NUM_THREADS; i++)
        begin
            sum = (TIDX_W+1)'(cur) + (TIDX_W+1)'(i);
            if (sum >= (TIDX_W+1)'(NUM_THREADS))
            begin
                sum = sum - (TIDX_W+1)'(NUM_THREADS);
            end
            t = sum[TIDX_W-1:0];
            if (ready[t] && (prio[t] < best))
            begin
                best        = prio[t];
                pick.found  = 1'b1;
                pick.thread = pts_pkg::THREAD_W'(t);
            end
        end
    end

endmodule

/* rtl/pts_wake.sv */
`timescale 1ns / 1ps

module pts_wake #(
    parameter int NUM_THREADS = 8,
    localparam int TIDX_W     = $clog2(NUM_THREADS)
) (
    input  logic [NUM_THREADS-1:0] waiting,
    input  logic [TIDX_W-1:0]      cur,
    output pts_pkg::pick_t         pick
);

    // Find the first waiter after the running thread, wrapping to it
    always_comb
    begin
        logic [TIDX_W:0]   sum;
        logic [TIDX_W-1:0] t;
        pick.found  = 1'b0;
        pick.thread = '0;
        for (int i = 1; i <= NUM_THREADS; i++)
        begin
            sum = (TIDX_W+1)'(cur) + (TIDX_W+1)'(i);
            if (sum >= (TIDX_W+1)'(NUM_THREADS))
            begin
                sum = sum - (TIDX_W+1)'(NUM_THREADS);
            end
            t = sum[TIDX_W-1:0];
            if (waiting[t] && !pick.found)
            begin
                pick.found  = 1'b1;
                pick.thread = pts_pkg::THREAD_W'(t);
            end
        end
    end

endmodule
